// ===== src/linear_interp_downsampler_unit_defines.svh =====
// assertion helpers for the checker file lidu_chk
`ifndef LINEAR_INTERP_DOWNSAMPLER_UNIT_DEFINES_SVH
`define LINEAR_INTERP_DOWNSAMPLER_UNIT_DEFINES_SVH

// same-cycle implication
`define LIDU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LIDU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lidu_pkg.sv =====
package lidu_pkg;

  localparam int unsigned SOURCE_RATE = 221680;
  localparam int unsigned RATE_W      = 18;
  localparam int unsigned RATE_RESET  = 44100;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned PHASE_W     = $clog2(SOURCE_RATE);

  // interpolation: rem * |prev - cur|, divided by the source rate
  localparam int unsigned MAG_W       = SAMPLE_W;
  localparam int unsigned PROD_W      = PHASE_W + MAG_W;
  localparam int unsigned EST_DROP    = 10;
  localparam int unsigned EST_SHIFT   = 28;
  localparam int unsigned EST_IN_W    = PROD_W - EST_DROP;
  localparam longint unsigned EST_RECIP =
    (64'd1 << (EST_DROP + EST_SHIFT)) / SOURCE_RATE;
  localparam int unsigned EST_RECIP_W = $clog2(EST_RECIP + 1);
  localparam int unsigned EST_PROD_W  = EST_IN_W + EST_RECIP_W;
  localparam int unsigned REM_W       = PHASE_W + 1;

  // level average, signed Q16.16
  localparam int unsigned AVG_W       = 32;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned ACC_W       = AVG_W + 4;
  localparam int unsigned ACC_MAG_W   = AVG_W + 3;
  localparam int unsigned DIV10_DROP  = 3;
  localparam int unsigned DIV10_IN_W  = ACC_MAG_W - DIV10_DROP;
  localparam logic [DIV10_IN_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam logic [4:0] TEN          = 5'd10;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [PHASE_W-1:0]         phase_t;

  typedef struct packed {
    logic    valid;
    phase_t  rem;
    sample_t prev;
    sample_t cur;
  } phase_item_t;

  typedef struct packed {
    logic    valid;
    sample_t sample;
  } blend_item_t;

endpackage

// ===== src/lidu_phase.sv =====
module lidu_phase (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         in_valid_i,
  input  lidu_pkg::sample_t            source_sample_i,
  input  logic                         cfg_valid_i,
  input  logic [lidu_pkg::RATE_W-1:0]  cfg_output_rate_i,
  output lidu_pkg::phase_item_t        item_o
);
  import lidu_pkg::*;

  localparam int unsigned SUM_W = PHASE_W + 1;

  phase_t      rate_q, rate_d;
  phase_t      phase_q, phase_d;
  sample_t     prev_q;
  logic        item_valid_q;
  phase_t      rem_q;
  sample_t     prev_item_q, cur_item_q;
  logic [SUM_W-1:0] sum;
  logic        wrap, accept;

  assign accept = in_valid_i && en_i;
  assign sum    = {1'b0, phase_q} + {1'b0, rate_q};
  assign wrap   = sum >= SUM_W'(SOURCE_RATE);
  assign phase_d = wrap ? PHASE_W'(sum - SUM_W'(SOURCE_RATE)) : sum[PHASE_W-1:0];

  // rates at or above the source rate act as one below it
  assign rate_d = (32'(cfg_output_rate_i) >= SOURCE_RATE) ?
                  PHASE_W'(SOURCE_RATE - 1) : PHASE_W'(cfg_output_rate_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q       <= PHASE_W'(RATE_RESET);
      phase_q      <= '0;
      prev_q       <= '0;
      item_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        rate_q <= rate_d;
      end
      if (accept) begin
        phase_q <= phase_d;
        prev_q  <= source_sample_i;
      end
      if (en_i) begin
        item_valid_q <= accept && wrap;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rem_q       <= phase_d;
      prev_item_q <= prev_q;
      cur_item_q  <= source_sample_i;
    end
  end

  assign item_o = '{valid: item_valid_q, rem: rem_q, prev: prev_item_q, cur: cur_item_q};

endmodule

// ===== src/lidu_blend.sv =====
module lidu_blend (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  lidu_pkg::phase_item_t  item_i,
  output lidu_pkg::blend_item_t  item_o
);
  import lidu_pkg::*;

  localparam int unsigned DIFF_W = SAMPLE_W + 1;
  localparam int unsigned OFS_W  = MAG_W + 2;

  // stage 1: rem * |prev - cur|
  logic [DIFF_W-1:0] diff;
  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod_a;

  // stage 2: quotient estimate from the top bits
  logic [EST_PROD_W-1:0] est_full;
  logic [MAG_W-1:0]      est;

  // stage 3: estimate times the source rate
  logic [PROD_W-1:0] back;

  // stage 5: one correction step and rounding toward zero
  logic              corr, nz;
  logic [MAG_W:0]    qf;
  logic [OFS_W-1:0]  qn, ofs, fl;
  sample_t           sample_d;

  logic              v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [PROD_W-1:0] a1_q, a2_q, a3_q, back3_q;
  logic [MAG_W-1:0]  q2_q, q3_q, q4_q;
  logic [REM_W-1:0]  r4_q;
  logic              neg1_q, neg2_q, neg3_q, neg4_q;
  sample_t           cur1_q, cur2_q, cur3_q, cur4_q, sample5_q;

  assign diff   = DIFF_W'($signed(item_i.prev)) - DIFF_W'($signed(item_i.cur));
  assign mag    = MAG_W'(diff[DIFF_W-1] ? -diff : diff);
  assign prod_a = PROD_W'(item_i.rem) * PROD_W'(mag);

  assign est_full = EST_PROD_W'(a1_q[PROD_W-1:EST_DROP]) * EST_PROD_W'(EST_RECIP);
  assign est      = MAG_W'(est_full >> EST_SHIFT);

  assign back = PROD_W'(q2_q) * PROD_W'(SOURCE_RATE);

  // estimate is low by at most one
  assign corr = r4_q >= REM_W'(SOURCE_RATE);
  assign nz   = corr ? (r4_q != REM_W'(SOURCE_RATE)) : (r4_q != '0);
  assign qf   = {1'b0, q4_q} + (MAG_W + 1)'(corr);
  assign qn   = OFS_W'(qf) + OFS_W'(nz);
  // floor of the blend, then step up when negative with a remainder
  assign ofs  = neg4_q ? OFS_W'(-qn) : OFS_W'(qf);
  assign fl   = OFS_W'($signed(cur4_q)) + ofs;
  assign sample_d = SAMPLE_W'(fl + OFS_W'(fl[OFS_W-1] && nz));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= item_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q      <= prod_a;
      neg1_q    <= diff[DIFF_W-1];
      cur1_q    <= item_i.cur;
      a2_q      <= a1_q;
      q2_q      <= est;
      neg2_q    <= neg1_q;
      cur2_q    <= cur1_q;
      a3_q      <= a2_q;
      q3_q      <= q2_q;
      back3_q   <= back;
      neg3_q    <= neg2_q;
      cur3_q    <= cur2_q;
      r4_q      <= REM_W'(a3_q - back3_q);
      q4_q      <= q3_q;
      neg4_q    <= neg3_q;
      cur4_q    <= cur3_q;
      sample5_q <= sample_d;
    end
  end

  assign item_o = '{valid: v5_q, sample: sample5_q};

endmodule

// ===== src/lidu_level.sv =====
module lidu_level (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lidu_pkg::blend_item_t  item_i,
  input  logic                   out_ready_i,
  output logic                   en_o,
  output logic                   out_valid_o,
  output lidu_pkg::sample_t      out_sample_o,
  output lidu_pkg::sample_t      level_o
);
  import lidu_pkg::*;

  logic [AVG_W-1:0]        avg_q, avg_d;
  logic [ACC_W-1:0]        avg_ext, smp_ext, acc, acc_abs;
  logic                    neg;
  logic [ACC_MAG_W-1:0]    mag;
  logic [2*DIV10_IN_W-1:0] prod;
  logic [AVG_W-1:0]        q0, q;
  logic [4:0]              r5;
  sample_t                 level_d;
  logic                    out_valid_q;
  sample_t                 out_sample_q, level_q;

  assign en_o = !out_valid_q || out_ready_i;

  // 9*avg + sample in Q16.16
  assign avg_ext = {{(ACC_W - AVG_W){avg_q[AVG_W-1]}}, avg_q};
  assign smp_ext = {{(ACC_W - SAMPLE_W){item_i.sample[SAMPLE_W-1]}}, item_i.sample};
  assign acc     = (avg_ext << 3) + avg_ext + (smp_ext << FRAC_W);
  assign neg     = acc[ACC_W-1];
  assign acc_abs = neg ? -acc : acc;
  assign mag     = acc_abs[ACC_MAG_W-1:0];

  // divide by ten: 4/5 of mag/8, then at most one step up
  assign prod = (2*DIV10_IN_W)'(mag[ACC_MAG_W-1:DIV10_DROP])
              * (2*DIV10_IN_W)'(DIV10_RECIP);
  assign q0   = AVG_W'(prod[2*DIV10_IN_W-1:DIV10_IN_W]);
  assign r5   = mag[4:0] - q0[4:0] * TEN;
  assign q    = q0 + AVG_W'(r5 >= TEN);

  assign avg_d   = neg ? -q : q;
  assign level_d = neg ? -q[AVG_W-1:FRAC_W] : q[AVG_W-1:FRAC_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      avg_q       <= '0;
    end else if (en_o) begin
      out_valid_q <= item_i.valid;
      if (item_i.valid) begin
        avg_q <= avg_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o && item_i.valid) begin
      out_sample_q <= item_i.sample;
      level_q      <= level_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign level_o      = level_q;

endmodule

// ===== src/linear_interp_downsampler_unit.sv =====
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o   source_sample_i
// out       output     out_valid_o / out_ready_i out_sample_o, level_o
// cfg       input      cfg_valid_i / cfg_ready_o cfg_output_rate_i
//
// one input item per cycle unless the pipeline holds; a result passes the phase
// item register, the divide-by-source-rate blend pipeline and the output register
// reset clears phase, previous sample, level average and all valid bits
// when the output register is full and not taken the whole pipeline holds
// and in_ready_o drops; cfg_ready_o is always high
module linear_interp_downsampler_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lidu_pkg::sample_t            source_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lidu_pkg::sample_t            out_sample_o,
  output lidu_pkg::sample_t            level_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lidu_pkg::RATE_W-1:0]  cfg_output_rate_i
);
  import lidu_pkg::*;

  logic        en;
  phase_item_t phase_item;
  blend_item_t blend_item;

  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  lidu_phase u_phase (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (en),
    .in_valid_i        (in_valid_i),
    .source_sample_i   (source_sample_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_output_rate_i (cfg_output_rate_i),
    .item_o            (phase_item)
  );

  lidu_blend u_blend (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .item_i (phase_item),
    .item_o (blend_item)
  );

  lidu_level u_level (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (blend_item),
    .out_ready_i  (out_ready_i),
    .en_o         (en),
    .out_valid_o  (out_valid_o),
    .out_sample_o (out_sample_o),
    .level_o      (level_o)
  );

endmodule

// ===== src/lidu_chk.sv =====
`include "linear_interp_downsampler_unit_defines.svh"

module lidu_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input lidu_pkg::sample_t  out_sample_o,
  input lidu_pkg::sample_t  level_o
);

  localparam int unsigned LAT = 7;

  logic [LAT-1:0] rdy_hist_q;
  logic [LAT-1:0] acc_hist_q;
  logic           no_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdy_hist_q <= '0;
      acc_hist_q <= '0;
    end else begin
      rdy_hist_q <= {rdy_hist_q[LAT-2:0], in_ready_o};
      acc_hist_q <= {acc_hist_q[LAT-2:0], in_valid_i && in_ready_o};
    end
  end

  // pipeline moved on every one of the last cycles of the latency
  assign no_stall = &rdy_hist_q;

  `LIDU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_sample_o) && $stable(level_o), "result changed while stalled")
  `LIDU_ASSERT_NOW(a_empty_ready, clk_i, rst_ni, !out_valid_o, in_ready_o, "input blocked with empty output register")
  `LIDU_ASSERT_NOW(a_latency, clk_i, rst_ni, out_valid_o && no_stall, acc_hist_q[LAT-1], "result without an item accepted at the pipeline latency")

endmodule

bind linear_interp_downsampler_unit lidu_chk u_lidu_chk (.*);
